// ===== rtl/sce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_pkg: shared types and constants of the stereo chorus
// Item types, configuration layout, microcode format and the control
// program, plus the sine table generator used at elaboration.
// ----------------------------------------------------------------------------
package sce_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int SWEEP_BITS  = 21;
	localparam int PHASE_BITS  = 24;
	localparam int FRAC_BITS   = 8;
	localparam int PROD_BITS   = 34;
	localparam int MUL_BITS    = 17;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t left_in;
		sample_t right_in;
	} in_item_t;

	typedef struct packed {
		sample_t left_out;
		sample_t right_out;
	} out_item_t;

	// configuration register file
	typedef struct packed {
		logic [12:0] min_delay;
		logic [11:0] sweep_width;
		logic [15:0] phase_step;
		logic [15:0] wet_gain;
		logic [2:0]  mix_mode;
	} cfg_t;

	localparam logic [2:0] REG_MIN_DELAY   = 3'd0;
	localparam logic [2:0] REG_SWEEP_WIDTH = 3'd1;
	localparam logic [2:0] REG_PHASE_STEP  = 3'd2;
	localparam logic [2:0] REG_WET_GAIN    = 3'd3;
	localparam logic [2:0] REG_MIX_MODE    = 3'd4;

	localparam logic [2:0] MIX_MONO      = 3'd0;
	localparam logic [2:0] MIX_WET_ONLY  = 3'd1;
	localparam logic [2:0] MIX_WET_LEFT  = 3'd2;
	localparam logic [2:0] MIX_WET_RIGHT = 3'd3;
	localparam logic [2:0] MIX_STEREO    = 3'd4;

	localparam int MIN_DELAY_RST   = 22;
	localparam int SWEEP_WIDTH_RST = 1103;

	localparam cfg_t CFG_RESET = '{
		min_delay:   13'(MIN_DELAY_RST),
		sweep_width: 12'(SWEEP_WIDTH_RST),
		phase_step:  16'd76,
		wet_gain:    16'd0,
		mix_mode:    MIX_STEREO
	};

	// midrange of the reset delays, in Q13.8
	localparam logic [SWEEP_BITS-1:0] SWEEP_RESET =
		SWEEP_BITS'(((2 * MIN_DELAY_RST + SWEEP_WIDTH_RST) / 2) << FRAC_BITS);

	// program steps
	typedef enum logic [2:0] {
		ST_WAIT_IN,
		ST_READ_A,
		ST_READ_B,
		ST_WEIGHT_B,
		ST_SUM,
		ST_WET,
		ST_OUTPUT
	} step_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_WAIT_IN,
		JMP_WAIT_OUT
	} jmp_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_TAP_A,
		RD_TAP_B
	} rd_sel_t;

	typedef enum logic [1:0] {
		MA_RDATA,
		MA_TAP,
		MA_SINE
	} mul_a_t;

	typedef enum logic [1:0] {
		MB_WA,
		MB_WB,
		MB_GAIN,
		MB_WIDTH
	} mul_b_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	// one control word
	typedef struct packed {
		jmp_t    jmp;
		step_t   target;
		logic    take_in;
		logic    mem_wr;
		rd_sel_t rd_sel;
		logic    pos_ld;
		logic    mul_en;
		mul_a_t  mul_a;
		mul_b_t  mul_b;
		acc_op_t acc_op;
		logic    sweep_ld;
		logic    finish;
	} ctrl_t;

	// control program
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = '0;
		c.jmp    = JMP_NEXT;
		c.target = ST_WAIT_IN;
		c.rd_sel = RD_NONE;
		c.mul_a  = MA_RDATA;
		c.mul_b  = MB_WA;
		c.acc_op = ACC_HOLD;
		unique case (s)
			ST_WAIT_IN: begin
				c.jmp     = JMP_WAIT_IN;
				c.take_in = 1'b1;
				c.mem_wr  = 1'b1;
			end
			ST_READ_A: begin
				c.rd_sel = RD_TAP_A;
				c.pos_ld = 1'b1;
				c.mul_en = 1'b1;
				c.mul_a  = MA_SINE;
				c.mul_b  = MB_WIDTH;
			end
			ST_READ_B: begin
				c.rd_sel   = RD_TAP_B;
				c.mul_en   = 1'b1;
				c.mul_a    = MA_RDATA;
				c.mul_b    = MB_WA;
				c.sweep_ld = 1'b1;
			end
			ST_WEIGHT_B: begin
				c.mul_en = 1'b1;
				c.mul_a  = MA_RDATA;
				c.mul_b  = MB_WB;
				c.acc_op = ACC_LOAD;
			end
			ST_SUM: begin
				c.acc_op = ACC_ADD;
			end
			ST_WET: begin
				c.mul_en = 1'b1;
				c.mul_a  = MA_TAP;
				c.mul_b  = MB_GAIN;
			end
			ST_OUTPUT: begin
				c.jmp    = JMP_WAIT_OUT;
				c.target = ST_WAIT_IN;
				c.finish = 1'b1;
			end
			default: begin
				c.jmp = JMP_NEXT;
			end
		endcase
		return c;
	endfunction

	// sin(pi/2 * t), t and result in Q30
	function automatic longint unsigned quarter_sine(input longint unsigned t);
		longint unsigned t2;
		longint unsigned p;
		t2 = (t * t) >> 30;
		p = 64'd5026995 - ((t2 * 64'd172272) >> 30);
		p = 64'd85569306 - ((t2 * p) >> 30);
		p = 64'd693598668 - ((t2 * p) >> 30);
		p = 64'd1686629713 - ((t2 * p) >> 30);
		return (t * p) >> 30;
	endfunction

	// one sine table entry, table size 2**lg
	function automatic sample_t sine_value(input int unsigned idx, input int unsigned lg);
		longint unsigned n;
		longint unsigned i4;
		longint unsigned q;
		longint unsigned r;
		longint unsigned t;
		longint unsigned s;
		sample_t v;
		n  = 64'd1 << lg;
		i4 = 64'(idx) << 2;
		q  = i4 >> lg;
		r  = i4 & (n - 64'd1);
		if (q[0])
			r = n - r;
		t = (r << 30) >> lg;
		s = (quarter_sine(t) + 64'd16384) >> 15;
		if (s > 64'd32767)
			s = 64'd32767;
		v = sample_t'(s[SAMPLE_BITS-1:0]);
		return q[1] ? -v : v;
	endfunction

endpackage

// ===== rtl/stereo_chorus_effect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_chorus_effect: LFO-swept chorus on a mono delay line
// Averages each stereo frame into a circular delay line, reads an
// interpolated tap behind the write pointer and mixes it with the dry
// input per the selected mode.
//
// channel   handshake              payload
// dry       dry_valid / dry_stall  dry_frame  (left_in, right_in)
// mix       mix_valid / mix_stall  mix_frame  (left_out, right_out)
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A frame runs through the microcode steps in order, sharing one multiplier
// and one delay-line read port; its result is written to the output
// register in the last step, once the output register is free.
// A frame is accepted only while the sequencer waits at its first step.
// The output register lets the next frame in while a result waits; the
// last step holds while the previous result is still stalled.
// After reset the block takes frames at once: unwritten delay entries
// read as zero through the fill count, so there is no clearing pass.
// ----------------------------------------------------------------------------
module stereo_chorus_effect
	import sce_pkg::*;
#(
	parameter int DELAY_DEPTH  = 8192,
	parameter int SINE_ENTRIES = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      dry_valid,
	output logic      dry_stall,
	input  in_item_t  dry_frame,
	output logic      mix_valid,
	input  logic      mix_stall,
	output out_item_t mix_frame,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int AW  = $clog2(DELAY_DEPTH);
	localparam int SLG = $clog2(SINE_ENTRIES);

	cfg_t           cfg_q;
	logic           mid_ld_q;
	ctrl_t          ctrl;
	logic           idle;
	logic           out_free;
	sample_t        sine;
	logic [SLG-1:0] sine_addr;
	logic [AW-1:0]  wp;
	sample_t        rd_data;
	sample_t        wr_data;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;

	assign cfg_ready = 1'b1;
	assign dry_stall = !idle;

	// configuration registers; a valid write to a defined register re-centers the sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= CFG_RESET;
			mid_ld_q <= 1'b0;
		end else begin
			mid_ld_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MIN_DELAY: begin
						cfg_q.min_delay <= cfg_data[12:0];
						mid_ld_q        <= 1'b1;
					end
					REG_SWEEP_WIDTH: begin
						cfg_q.sweep_width <= cfg_data[11:0];
						mid_ld_q          <= 1'b1;
					end
					REG_PHASE_STEP: begin
						cfg_q.phase_step <= cfg_data;
						mid_ld_q         <= 1'b1;
					end
					REG_WET_GAIN: begin
						cfg_q.wet_gain <= cfg_data;
						mid_ld_q       <= 1'b1;
					end
					REG_MIX_MODE: begin
						cfg_q.mix_mode <= cfg_data[2:0];
						mid_ld_q       <= 1'b1;
					end
					default: begin
						mid_ld_q <= 1'b0;
					end
				endcase
			end
		end
	end

	sce_sequencer u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (dry_valid),
		.out_free   (out_free),
		.idle       (idle),
		.ctrl       (ctrl)
	);

	sce_sine_rom #(
		.ENTRIES (SINE_ENTRIES),
		.LG      (SLG)
	) u_rom (
		.clk  (clk),
		.addr (sine_addr),
		.data (sine)
	);

	sce_delay_mem #(
		.DEPTH (DELAY_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ctrl.mem_wr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wp      (wp),
		.rd_data (rd_data)
	);

	sce_datapath #(
		.AW  (AW),
		.SLG (SLG)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.item      (dry_frame),
		.cfg       (cfg_q),
		.mid_ld    (mid_ld_q),
		.sine      (sine),
		.wp        (wp),
		.rd_data   (rd_data),
		.out_stall (mix_stall),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.sine_addr (sine_addr),
		.out_valid (mix_valid),
		.out_item  (mix_frame),
		.out_free  (out_free)
	);

endmodule

// ===== rtl/sce_sine_rom.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_sine_rom: LFO sine table
// Constant table of one full sine period, built at elaboration, with a
// registered read port.
// ----------------------------------------------------------------------------
module sce_sine_rom
	import sce_pkg::*;
#(
	parameter int ENTRIES = 1024,
	parameter int LG      = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic [LG-1:0] addr,
	output sample_t       data
);

	sample_t rom [ENTRIES];
	sample_t data_q;

	// table contents
	for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
		assign rom[g] = sine_value(g, LG);
	end

	// registered read
	always_ff @(posedge clk) begin
		data_q <= rom[addr];
	end

	assign data = data_q;

endmodule

// ===== rtl/sce_delay_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_delay_mem: circular delay line
// Single write port at the write pointer, one registered read port. A
// fill count (pointer plus wrap flag) makes never-written entries read
// as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module sce_delay_mem
	import sce_pkg::*;
#(
	parameter int DEPTH = 8192,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  sample_t       wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [AW-1:0] wp,
	output sample_t       rd_data
);

	sample_t       mem [DEPTH];
	sample_t       rd_q;
	logic [AW-1:0] wp_q;
	logic          wrapped_q;
	logic          rd_ok_q;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wp_q] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	// write pointer and fill tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + AW'(1);
				if (wp_q == AW'(DEPTH - 1))
					wrapped_q <= 1'b1;
			end
			if (rd_en)
				rd_ok_q <= wrapped_q || (rd_addr < wp_q);
		end
	end

	assign wp      = wp_q;
	assign rd_data = rd_ok_q ? rd_q : '0;

endmodule

// ===== rtl/sce_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_sequencer: microcode sequencer
// Step counter over the control program with wait-for-input and
// wait-for-output jumps; actions of a waiting step are held off.
// ----------------------------------------------------------------------------
module sce_sequencer
	import sce_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  logic  out_free,
	output logic  idle,
	output ctrl_t ctrl
);

	step_t pc_q;
	step_t pc_nx;
	ctrl_t word;
	logic  go;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= ST_WAIT_IN;
		else
			pc_q <= pc_nx;
	end

	// control word fetch, jump condition and next step
	always_comb begin
		word = ucode(pc_q);
		unique case (word.jmp)
			JMP_WAIT_IN:  go = item_valid;
			JMP_WAIT_OUT: go = out_free;
			default:      go = 1'b1;
		endcase
		pc_nx = pc_q;
		if (go) begin
			if (word.jmp == JMP_WAIT_OUT)
				pc_nx = word.target;
			else
				pc_nx = step_t'(3'(pc_q + 3'd1));
		end
		ctrl = word;
		if (!go) begin
			ctrl.take_in = 1'b0;
			ctrl.mem_wr  = 1'b0;
			ctrl.finish  = 1'b0;
		end
	end

	assign idle = (pc_q == ST_WAIT_IN);

endmodule

// ===== rtl/sce_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_datapath: chorus arithmetic
// Input latch, tap position, one shared 17x17 multiplier with product
// register, accumulator, mix and saturation, LFO phase and sweep delay,
// and the output register.
// ----------------------------------------------------------------------------
module sce_datapath
	import sce_pkg::*;
#(
	parameter int AW  = 13,
	parameter int SLG = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ctrl_t          ctrl,
	input  in_item_t       item,
	input  cfg_t           cfg,
	input  logic           mid_ld,
	input  sample_t        sine,
	input  logic [AW-1:0]  wp,
	input  sample_t        rd_data,
	input  logic           out_stall,
	output sample_t        wr_data,
	output logic           rd_en,
	output logic [AW-1:0]  rd_addr,
	output logic [SLG-1:0] sine_addr,
	output logic           out_valid,
	output out_item_t      out_item,
	output logic           out_free
);

	localparam int PW        = AW + FRAC_BITS;
	localparam int SAT_HI_I  = (1 << (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [19:0] SAT_HI = 20'(SAT_HI_I);
	localparam logic signed [19:0] SAT_LO = -20'(SAT_HI_I) - 20'sd1;
	localparam logic [SWEEP_BITS-1:0] SWEEP_MAX = '1;

	sample_t                  l_q;
	sample_t                  r_q;
	logic [AW-1:0]            i2_q;
	logic [FRAC_BITS-1:0]     fr_q;
	logic signed [PROD_BITS-1:0] prod_q;
	logic signed [PROD_BITS-1:0] acc_q;
	logic [SWEEP_BITS-1:0]    sweep_q;
	logic [SWEEP_BITS-1:0]    sweep_nx_q;
	logic [PHASE_BITS-1:0]    phase_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	logic signed [SAMPLE_BITS:0] in_sum;
	logic [PW-1:0]            pos;
	logic [FRAC_BITS:0]       wa;
	sample_t                  tap;
	logic [SAMPLE_BITS-1:0]   sine_off;
	logic signed [MUL_BITS-1:0] mul_a;
	logic signed [MUL_BITS-1:0] mul_b;
	logic [SWEEP_BITS:0]      sweep_sum;
	logic [SWEEP_BITS-1:0]    sweep_calc;
	logic [13:0]              mid;
	logic [SWEEP_BITS:0]      mid_sum;
	logic [SWEEP_BITS-1:0]    mid_sweep;
	logic                     ldry;
	logic                     rdry;
	logic                     lwet;
	logic                     rwet;
	logic                     rneg;
	logic signed [PROD_BITS-1:0] wet_l;
	logic signed [PROD_BITS-1:0] wet_r;
	logic signed [PROD_BITS-1:0] rnd_l;
	logic signed [PROD_BITS-1:0] rnd_r;
	logic signed [19:0]       lo;
	logic signed [19:0]       ro;

	function automatic sample_t sat16(input logic signed [19:0] v);
		if (v > SAT_HI)
			return sample_t'(SAT_HI);
		if (v < SAT_LO)
			return sample_t'(SAT_LO);
		return sample_t'(v);
	endfunction

	// channel average written to the delay line
	assign in_sum  = (SAMPLE_BITS + 1)'(item.left_in) + (SAMPLE_BITS + 1)'(item.right_in);
	assign wr_data = in_sum[SAMPLE_BITS:1];

	// fractional tap position behind the write pointer
	assign pos     = {wp, {FRAC_BITS{1'b0}}} - PW'(sweep_q);
	assign rd_en   = (ctrl.rd_sel != RD_NONE);
	assign rd_addr = (ctrl.rd_sel == RD_TAP_B) ? i2_q : pos[PW-1:FRAC_BITS];

	assign sine_addr = phase_q[PHASE_BITS-1 -: SLG];

	// multiplier operand select
	assign wa       = (FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, fr_q};
	assign tap      = acc_q[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
	assign sine_off = {~sine[SAMPLE_BITS-1], sine[SAMPLE_BITS-2:0]};

	always_comb begin
		unique case (ctrl.mul_a)
			MA_RDATA: mul_a = MUL_BITS'(rd_data);
			MA_TAP:   mul_a = MUL_BITS'(tap);
			MA_SINE:  mul_a = {1'b0, sine_off};
			default:  mul_a = '0;
		endcase
		unique case (ctrl.mul_b)
			MB_WA:    mul_b = {{(MUL_BITS - FRAC_BITS - 1){1'b0}}, wa};
			MB_WB:    mul_b = {{(MUL_BITS - FRAC_BITS){1'b0}}, fr_q};
			MB_GAIN:  mul_b = {1'b0, cfg.wet_gain};
			MB_WIDTH: mul_b = {5'd0, cfg.sweep_width};
			default:  mul_b = '0;
		endcase
	end

	// next sweep delay from the current sine product
	assign sweep_sum  = {1'b0, cfg.min_delay, {FRAC_BITS{1'b0}}} + {2'b00, prod_q[27:8]};
	assign sweep_calc = sweep_sum[SWEEP_BITS] ? SWEEP_MAX : sweep_sum[SWEEP_BITS-1:0];

	// midrange delay after a configuration write
	assign mid       = {1'b0, cfg.min_delay} + {3'd0, cfg.sweep_width[11:1]};
	assign mid_sum   = {mid, {FRAC_BITS{1'b0}}};
	assign mid_sweep = mid_sum[SWEEP_BITS] ? SWEEP_MAX : mid_sum[SWEEP_BITS-1:0];

	// mix mode decode
	always_comb begin
		unique case (cfg.mix_mode)
			MIX_WET_ONLY: begin
				ldry = 1'b0; rdry = 1'b0; lwet = 1'b1; rwet = 1'b1; rneg = 1'b0;
			end
			MIX_WET_LEFT: begin
				ldry = 1'b0; rdry = 1'b1; lwet = 1'b1; rwet = 1'b0; rneg = 1'b0;
			end
			MIX_WET_RIGHT: begin
				ldry = 1'b1; rdry = 1'b0; lwet = 1'b0; rwet = 1'b1; rneg = 1'b0;
			end
			MIX_STEREO: begin
				ldry = 1'b0; rdry = 1'b0; lwet = 1'b1; rwet = 1'b1; rneg = 1'b1;
			end
			default: begin
				ldry = 1'b1; rdry = 1'b1; lwet = 1'b1; rwet = 1'b1; rneg = 1'b0;
			end
		endcase
	end

	// wet rounding, dry add and saturation
	always_comb begin
		wet_l = lwet ? prod_q : '0;
		wet_r = rwet ? (rneg ? -prod_q : prod_q) : '0;
		rnd_l = wet_l + PROD_BITS'(16384);
		rnd_r = wet_r + PROD_BITS'(16384);
		lo = (ldry ? 20'(l_q) : 20'sd0) + 20'(signed'(rnd_l[PROD_BITS-1:15]));
		ro = (rdry ? 20'(r_q) : 20'sd0) + 20'(signed'(rnd_r[PROD_BITS-1:15]));
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.take_in) begin
			l_q <= item.left_in;
			r_q <= item.right_in;
		end
		if (ctrl.pos_ld) begin
			i2_q <= pos[PW-1:FRAC_BITS] + AW'(1);
			fr_q <= pos[FRAC_BITS-1:0];
		end
		if (ctrl.mul_en)
			prod_q <= mul_a * mul_b;
		unique case (ctrl.acc_op)
			ACC_LOAD: acc_q <= prod_q + PROD_BITS'(128);
			ACC_ADD:  acc_q <= acc_q + prod_q;
			default:  acc_q <= acc_q;
		endcase
		if (ctrl.sweep_ld)
			sweep_nx_q <= sweep_calc;
		if (ctrl.finish)
			out_q <= '{left_out: sat16(lo), right_out: sat16(ro)};
	end

	// lfo state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= SWEEP_RESET;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.finish) begin
				sweep_q <= sweep_nx_q;
				phase_q <= phase_q + PHASE_BITS'(cfg.phase_step);
			end else if (mid_ld) begin
				sweep_q <= mid_sweep;
			end
			if (ctrl.finish)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

endmodule

// ===== rtl/sce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sce_checker: port-level checks of the stereo chorus
// Watches the top-level ports for frame pacing and output register
// behavior; attached to the top level by a bind.
// ----------------------------------------------------------------------------
module sce_checker
	import sce_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      dry_valid,
	input logic      dry_stall,
	input logic      mix_valid,
	input logic      mix_stall,
	input out_item_t mix_frame
);

	logic dry_acc;

	assign dry_acc = dry_valid && !dry_stall;

	// a frame keeps the block busy through all of its working steps
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		dry_acc |=> dry_stall ##1 dry_stall ##1 dry_stall ##1 dry_stall
			##1 dry_stall ##1 dry_stall)
		else $error("frame accepted while previous frame in progress");

	// a new result appears only at the end of a frame in progress
	a_result_from_frame: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mix_valid) |-> $past(dry_stall))
		else $error("result without a frame in progress");

	// returning to idle leaves a result in the output register
	a_idle_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(dry_stall) |-> mix_valid)
		else $error("frame finished without a result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid && mix_stall |=> mix_valid && $stable(mix_frame))
		else $error("stalled result changed");

endmodule

bind stereo_chorus_effect sce_checker u_checker (.*);

// ===== tb/chorus_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chorus_checker: predicts and checks the chorus mix output
// Watches the dry, mix and cfg channels. Each accepted dry frame runs
// through an independent model of the delay line, LFO and mixer, and the
// predicted mix frame is queued. Each accepted mix frame is compared
// field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module chorus_checker
	import sce_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        dry_valid,
	input  logic        dry_stall,
	input  in_item_t    dry_frame,
	input  logic        mix_valid,
	input  logic        mix_stall,
	input  out_item_t   mix_frame,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          frames_due
);

	localparam int       LINE_DEPTH   = 8192;
	localparam int       SINE_SIZE    = 1024;
	localparam longint   SWEEP_LIMIT  = 2097151;
	localparam longint   SAMPLE_MAX   = 32767;
	localparam longint   SAMPLE_MIN   = -32768;

	// model state
	sample_t     echo_line [LINE_DEPTH];
	logic [12:0] wr_ptr;
	logic [23:0] lfo_acc;
	logic [20:0] sweep_q8;
	cfg_t        regs;
	int          sine_tab [SINE_SIZE];
	out_item_t   mix_expected [$];

	initial mismatches = 0;
	initial frames_due = 0;

	// sine table by quarter-wave symmetry and an odd polynomial in Q30
	function automatic int sine_entry(input int unsigned i);
		longint unsigned quad, r, t, t2, p, s;
		quad = (4 * i) / SINE_SIZE;
		r    = (4 * i) % SINE_SIZE;
		if (quad[0])
			r = SINE_SIZE - r;
		t  = (r << 30) / SINE_SIZE;
		t2 = (t * t) >> 30;
		p  = 64'd5026995 - ((t2 * 64'd172272) >> 30);
		p  = 64'd85569306 - ((t2 * p) >> 30);
		p  = 64'd693598668 - ((t2 * p) >> 30);
		p  = 64'd1686629713 - ((t2 * p) >> 30);
		s  = (((t * p) >> 30) + 64'd16384) >> 15;
		if (s > 64'd32767)
			s = 64'd32767;
		return quad[1] ? -int'(s) : int'(s);
	endfunction

	initial begin
		for (int k = 0; k < SINE_SIZE; k++)
			sine_tab[k] = sine_entry(k);
	end

	// sweep center, Q13.8, saturated
	function automatic logic [20:0] center_sweep(input cfg_t c);
		longint mid;
		mid = ((2 * longint'(c.min_delay) + longint'(c.sweep_width)) / 2) << 8;
		return (mid > SWEEP_LIMIT) ? 21'(SWEEP_LIMIT) : mid[20:0];
	endfunction

	function automatic sample_t clip(input longint v);
		if (v > SAMPLE_MAX)
			return sample_t'(SAMPLE_MAX);
		if (v < SAMPLE_MIN)
			return sample_t'(SAMPLE_MIN);
		return sample_t'(v);
	endfunction

	// register write; unknown indexes leave everything alone
	function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
		case (idx)
			REG_MIN_DELAY:   regs.min_delay   = val[12:0];
			REG_SWEEP_WIDTH: regs.sweep_width = val[11:0];
			REG_PHASE_STEP:  regs.phase_step  = val;
			REG_WET_GAIN:    regs.wet_gain    = val;
			REG_MIX_MODE:    regs.mix_mode    = val[2:0];
			default:         return;
		endcase
		sweep_q8 = center_sweep(regs);
	endfunction

	// one frame through delay line, interpolated tap, mixer and LFO
	function automatic out_item_t predict_mix(input in_item_t f);
		longint      l, r, frac, tap, lo, ro, sw;
		logic [20:0] pos;
		logic [12:0] ia, ib;
		int          ldry, rdry, lwet, rwet;
		out_item_t   res;
		l = f.left_in;
		r = f.right_in;
		echo_line[wr_ptr] = sample_t'((l + r) >>> 1);
		wr_ptr = wr_ptr + 13'd1;

		// tap position wraps around the line
		pos  = {wr_ptr, 8'd0} - sweep_q8;
		ia   = pos[20:8];
		ib   = ia + 13'd1;
		frac = pos[7:0];
		tap  = (longint'(echo_line[ia]) * (256 - frac)
			+ longint'(echo_line[ib]) * frac + 128) >>> 8;

		case (regs.mix_mode)
			MIX_WET_ONLY:  begin ldry = 0; rdry = 0; lwet = 1; rwet = 1;  end
			MIX_WET_LEFT:  begin ldry = 0; rdry = 1; lwet = 1; rwet = 0;  end
			MIX_WET_RIGHT: begin ldry = 1; rdry = 0; lwet = 0; rwet = 1;  end
			MIX_STEREO:    begin ldry = 0; rdry = 0; lwet = 1; rwet = -1; end
			default:       begin ldry = 1; rdry = 1; lwet = 1; rwet = 1;  end
		endcase

		lo = ldry * l + ((lwet * longint'(regs.wet_gain) * tap + 16384) >>> 15);
		ro = rdry * r + ((rwet * longint'(regs.wet_gain) * tap + 16384) >>> 15);
		res.left_out  = clip(lo);
		res.right_out = clip(ro);

		// next sweep from the current phase, then advance the LFO
		sw = (longint'(regs.min_delay) << 8)
			+ ((longint'(regs.sweep_width) * (sine_tab[lfo_acc[23:14]] + 32768)) >>> 8);
		sweep_q8 = (sw > SWEEP_LIMIT) ? 21'(SWEEP_LIMIT) : sw[20:0];
		lfo_acc  = lfo_acc + 24'(regs.phase_step);
		return res;
	endfunction

	// channel monitor
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t want;
		if (!arst_n) begin
			for (int k = 0; k < LINE_DEPTH; k++)
				echo_line[k] = '0;
			wr_ptr   = '0;
			lfo_acc  = '0;
			regs     = CFG_RESET;
			sweep_q8 = center_sweep(CFG_RESET);
			mix_expected.delete();
			frames_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);

			// compare mix item with the oldest prediction
			if (mix_valid && !mix_stall) begin
				if (mix_expected.size() == 0) begin
					mismatches <= mismatches + 1;
					$display("%0t: mix item expected none got %0d %0d",
						$time, mix_frame.left_out, mix_frame.right_out);
				end else begin
					want = mix_expected.pop_front();
					if (mix_frame.left_out !== want.left_out ||
						mix_frame.right_out !== want.right_out) begin
						mismatches <= mismatches + 1;
						if (mix_frame.left_out !== want.left_out)
							$display("%0t: left_out expected %0d got %0d",
								$time, want.left_out, mix_frame.left_out);
						if (mix_frame.right_out !== want.right_out)
							$display("%0t: right_out expected %0d got %0d",
								$time, want.right_out, mix_frame.right_out);
					end
				end
			end

			if (dry_valid && !dry_stall)
				mix_expected.push_back(predict_mix(dry_frame));

			frames_due <= mix_expected.size();
		end
	end

endmodule

// ===== tb/stereo_chorus_effect_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_chorus_effect_tb: top of the chorus testbench
// Drives dry frames and register writes, stalls the mix side at random
// and once for a long stretch, and reports the verdict from the checker.
// A short directed pass covers sample extremes and every mix code, then
// random frames run under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module stereo_chorus_effect_tb;
	import sce_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int HOLD_CYCLES   = 300;
	localparam int HOLD_AFTER    = 150;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASES        = 7;
	localparam int PHASE_FRAMES  = 250;
	localparam int MIX_CODES     = 8;
	localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
	localparam sample_t S_MAX = 16'sh7fff;
	localparam sample_t S_MIN = 16'sh8000;

	// setting kinds for the random phases
	typedef enum int {
		SET_RANDOM,
		SET_ALL_LOW,
		SET_ALL_HIGH,
		SET_RANGE_TOP
	} setting_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        dry_valid = 1'b0;
	in_item_t    dry_frame = '0;
	logic        mix_stall = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;
	logic        dry_stall;
	logic        mix_valid;
	out_item_t   mix_frame;
	logic        cfg_ready;
	int          mismatches;
	int          frames_due;

	int   send_idle_pct = 18;
	int   recv_idle_pct = 72;
	logic stall_hold    = 1'b0;
	int   frames_sent   = 0;
	int   cycle_count   = 0;

	stereo_chorus_effect dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.dry_valid (dry_valid),
		.dry_stall (dry_stall),
		.dry_frame (dry_frame),
		.mix_valid (mix_valid),
		.mix_stall (mix_stall),
		.mix_frame (mix_frame),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	chorus_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.dry_valid  (dry_valid),
		.dry_stall  (dry_stall),
		.dry_frame  (dry_frame),
		.mix_valid  (mix_valid),
		.mix_stall  (mix_stall),
		.mix_frame  (mix_frame),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.frames_due (frames_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// mix side back-pressure
	always @(posedge clk) begin
		mix_stall <= stall_hold || ($urandom_range(99) < recv_idle_pct);
	end

	// one long hold-off while frames keep coming
	initial begin
		wait (frames_sent >= HOLD_AFTER);
		@(posedge clk);
		stall_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		stall_hold <= 1'b0;
	end

	// offer one frame, valid stays up for a following item
	task automatic send_frame(input sample_t l, input sample_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			dry_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		dry_valid          <= 1'b1;
		dry_frame.left_in  <= l;
		dry_frame.right_in <= r;
		@(posedge clk);
		while (dry_stall) @(posedge clk);
		frames_sent++;
	endtask

	// stop offering and wait until every mix item is out
	task automatic drain();
		dry_valid <= 1'b0;
		@(posedge clk);
		while (frames_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, valid left up for back-to-back writes
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// full register load plus one write to an unused index
	task automatic load_regs(input logic [15:0] min_d, input logic [15:0] width,
		input logic [15:0] step, input logic [15:0] gain, input logic [15:0] mode);
		write_reg(REG_MIN_DELAY, min_d);
		write_reg(REG_SWEEP_WIDTH, width);
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_WET_GAIN, gain);
		write_reg(REG_MIX_MODE, mode);
		write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic setup_phase(input setting_t kind);
		case (kind)
			SET_ALL_LOW:
				load_regs(16'd0, 16'd0, 16'd0, 16'd32768, 16'($urandom_range(MIX_CODES - 1)));
			SET_ALL_HIGH:
				load_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
			SET_RANGE_TOP:
				load_regs(16'd4410, 16'd2205, 16'($urandom), 16'd32768,
					16'($urandom_range(MIX_CODES - 1)));
			default:
				load_regs(16'($urandom_range(0, 400)), 16'($urandom_range(0, 2205)),
					16'($urandom), 16'($urandom_range(0, 40000)),
					16'($urandom_range(MIX_CODES - 1)));
		endcase
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(7))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return sample_t'($urandom_range(0, 511)) - sample_t'(256);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// stimulus and verdict
	initial begin
		setting_t plan [PHASES];
		plan = '{SET_RANDOM, SET_ALL_LOW, SET_ALL_HIGH, SET_RANDOM,
			SET_RANGE_TOP, SET_RANDOM, SET_RANDOM};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings
		send_frame(S_MAX, S_MAX);
		send_frame(S_MIN, S_MIN);
		send_frame(S_MAX, S_MIN);
		drain();

		// every mix code with a gain far above unity, so outputs saturate
		load_regs(16'd1, 16'd3, 16'd40000, 16'hffff, 16'(MIX_MONO));
		@(posedge clk);
		for (int m = 0; m < MIX_CODES; m++) begin
			write_reg(REG_MIX_MODE, 16'(m));
			cfg_valid <= 1'b0;
			send_frame(S_MAX, S_MAX);
			send_frame(S_MIN, S_MIN);
			drain();
		end

		// averaging rounds toward minus infinity
		send_frame(-16'sd1, 16'sd0);
		send_frame(16'sd0, -16'sd1);
		send_frame(-16'sd1, -16'sd1);
		send_frame(16'sd1, 16'sd0);
		drain();

		// random phases: sender/receiver idle, then swapped, then none
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 18;
				recv_idle_pct = 72;
			end else if (ph < 4) begin
				send_idle_pct = 72;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			setup_phase(plan[ph]);
			for (int k = 0; k < PHASE_FRAMES; k++)
				send_frame(pick_sample(), pick_sample());
			drain();
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sce_pkg.sv
rtl/sce_sine_rom.sv
rtl/sce_delay_mem.sv
rtl/sce_sequencer.sv
rtl/sce_datapath.sv
rtl/stereo_chorus_effect.sv
rtl/sce_checker.sv
tb/chorus_checker.sv
tb/stereo_chorus_effect_tb.sv
